// ===== hdl/lp2w_pkg.sv =====
package lp2w_pkg;

  // Angle bookkeeping in units of 1/64 degree.
  localparam logic [15:0] FULL_TURN       = 16'd23040;
  localparam logic [15:0] TWO_TURNS       = 16'd46080;
  localparam logic [12:0] QUARTER_TURN    = 13'd5760;
  localparam logic [14:0] HALF_TURN       = 15'd11520;
  localparam logic [14:0] THREE_QUARTERS  = 15'd17280;

  // pi/11520 in Q40, and the rounding term that brings the product to Q30.
  localparam logic [28:0] RAD_PER_UNIT_Q40 = 29'd299845282;
  localparam logic [42:0] Q40_TO_Q30_HALF  = 43'd512;
  localparam logic [30:0] ONE_Q30          = 31'h4000_0000;

  localparam int unsigned POSE_FRAC_BITS = 14;
  localparam int unsigned HORNER_STEPS   = 6;
  localparam int unsigned RECIP_SHIFT    = 34;

  // Quadrant codes of the reduced angle.
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  // Lanes of the sine evaluation: offset a and its complement.
  localparam int unsigned LANE_A = 0;
  localparam int unsigned LANE_B = 1;

  // Configuration register indexes.
  localparam logic [2:0] REG_POSE_COS = 3'd0;
  localparam logic [2:0] REG_POSE_SIN = 3'd1;
  localparam logic [2:0] REG_POSE_X   = 3'd2;
  localparam logic [2:0] REG_POSE_Y   = 3'd3;
  localparam logic [2:0] REG_MIRROR_Y = 3'd4;

  typedef struct packed {
    logic signed [15:0] pose_cos;
    logic signed [15:0] pose_sin;
    logic signed [30:0] pose_x;
    logic signed [30:0] pose_y;
    logic               mirror_y;
  } lp2w_cfg_t;

  // One lane of the Horner evaluation: argument, its square and the partial sum.
  typedef struct packed {
    logic [30:0] x;
    logic [31:0] x2;
    logic [30:0] t;
  } lp2w_lane_t;

  typedef struct packed {
    lp2w_lane_t [1:0] lane;
    logic [1:0]       quad;
    logic [15:0]      distance;
  } lp2w_item_t;

  // Divisors of the Taylor series in Horner order.
  function automatic int unsigned lp2w_div_f(input int unsigned step);
    int unsigned div;
    case (step)
      0:       div = 156;
      1:       div = 110;
      2:       div = 72;
      3:       div = 42;
      4:       div = 20;
      default: div = 6;
    endcase
    return div;
  endfunction

endpackage

// ===== hdl/lp2w_angle.sv =====
module lp2w_angle import lp2w_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] angle_q6_i,
  input  logic [15:0] distance_q2_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output lp2w_item_t  out_item_o
);

  logic [2:0] v_q;
  logic [2:0] en;

  logic [15:0] red_d;
  logic [14:0] r_d;
  logic [1:0]  quad_d;
  logic [14:0] base_d;
  logic [12:0] a_d;

  logic [1:0]  quad1_q, quad2_q;
  logic [15:0] dist1_q, dist2_q;
  logic [12:0] off_q [2];
  logic [30:0] x_q   [2];
  logic [30:0] x_d   [2];
  logic [42:0] xp    [2];

  lp2w_item_t item_d, item_q;

  always_comb begin
    en[2] = !v_q[2] || out_ready_i;
    en[1] = !v_q[1] || en[2];
    en[0] = !v_q[0] || en[1];
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[2];
  assign out_item_o  = item_q;

  // Stage 1: reduce to one turn and split into quadrant and offset.
  always_comb begin
    if (angle_q6_i >= TWO_TURNS) begin
      red_d = angle_q6_i - TWO_TURNS;
    end else if (angle_q6_i >= FULL_TURN) begin
      red_d = angle_q6_i - FULL_TURN;
    end else begin
      red_d = angle_q6_i;
    end
    r_d = red_d[14:0];
    if (r_d >= THREE_QUARTERS) begin
      quad_d = QUAD_3;
      base_d = THREE_QUARTERS;
    end else if (r_d >= HALF_TURN) begin
      quad_d = QUAD_2;
      base_d = HALF_TURN;
    end else if (r_d >= 15'(QUARTER_TURN)) begin
      quad_d = QUAD_1;
      base_d = 15'(QUARTER_TURN);
    end else begin
      quad_d = QUAD_0;
      base_d = '0;
    end
    a_d = 13'(r_d - base_d);
  end

  // Stage 2: offsets to radians in Q30. Stage 3: squares.
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      xp[l]  = 43'(off_q[l]) * 43'(RAD_PER_UNIT_Q40) + Q40_TO_Q30_HALF;
      x_d[l] = xp[l][40:10];
    end
  end

  always_comb begin
    logic [61:0] sq;
    item_d.quad     = quad2_q;
    item_d.distance = dist2_q;
    for (int l = 0; l < 2; l++) begin
      sq = 62'(x_q[l]) * 62'(x_q[l]);
      item_d.lane[l].x  = x_q[l];
      item_d.lane[l].x2 = sq[61:30];
      item_d.lane[l].t  = ONE_Q30;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      if (en[1]) v_q[1] <= v_q[0];
      if (en[2]) v_q[2] <= v_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      quad1_q       <= quad_d;
      dist1_q       <= distance_q2_i;
      off_q[LANE_A] <= a_d;
      off_q[LANE_B] <= QUARTER_TURN - a_d;
    end
    if (en[1]) begin
      quad2_q <= quad1_q;
      dist2_q <= dist1_q;
      x_q     <= x_d;
    end
    if (en[2]) begin
      item_q <= item_d;
    end
  end

endmodule

// ===== hdl/lp2w_horner.sv =====
module lp2w_horner import lp2w_pkg::*; #(
  parameter int unsigned STEP = 0
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  lp2w_item_t in_item_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output lp2w_item_t out_item_o
);

  localparam int unsigned Div   = lp2w_div_f(STEP);
  localparam logic [31:0] Recip = 32'((64'd1 << RECIP_SHIFT) / Div);

  logic [2:0] v_q;
  logic [2:0] en;

  lp2w_item_t itm_q [3];
  lp2w_item_t itm_d;

  logic [31:0] p_d  [2];
  logic [31:0] p_q  [2];
  logic [31:0] p2_q [2];
  logic [29:0] q0_d [2];
  logic [29:0] q0_q [2];

  always_comb begin
    en[2] = !v_q[2] || out_ready_i;
    en[1] = !v_q[1] || en[2];
    en[0] = !v_q[0] || en[1];
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[2];
  assign out_item_o  = itm_q[2];

  // Stage 1: Q30 product of the square and the running term.
  always_comb begin
    logic [62:0] prod;
    for (int l = 0; l < 2; l++) begin
      prod   = 63'(in_item_i.lane[l].x2) * 63'(in_item_i.lane[l].t);
      p_d[l] = prod[61:30];
    end
  end

  // Stage 2: quotient estimate by the reciprocal; it is exact or one short.
  always_comb begin
    logic [63:0] m;
    for (int l = 0; l < 2; l++) begin
      m       = 64'(p_q[l]) * 64'(Recip);
      q0_d[l] = 30'(m >> RECIP_SHIFT);
    end
  end

  // Stage 3: correct the quotient and form the new term.
  always_comb begin
    logic [32:0] rem;
    logic [30:0] q;
    itm_d = itm_q[1];
    for (int l = 0; l < 2; l++) begin
      rem = 33'(p2_q[l]) - 33'(q0_q[l]) * 33'(Div);
      q   = 31'(q0_q[l]) + ((rem >= 33'(Div)) ? 31'd1 : 31'd0);
      itm_d.lane[l].t = ONE_Q30 - q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      if (en[1]) v_q[1] <= v_q[0];
      if (en[2]) v_q[2] <= v_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      itm_q[0] <= in_item_i;
      p_q      <= p_d;
    end
    if (en[1]) begin
      itm_q[1] <= itm_q[0];
      p2_q     <= p_q;
      q0_q     <= q0_d;
    end
    if (en[2]) begin
      itm_q[2] <= itm_d;
    end
  end

endmodule

// ===== hdl/lp2w_sine_out.sv =====
module lp2w_sine_out import lp2w_pkg::*; #(
  parameter int unsigned TRIG_FRAC_BITS = 14
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             mirror_y_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  lp2w_item_t                       in_item_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [TRIG_FRAC_BITS+18:0] px_o,
  output logic signed [TRIG_FRAC_BITS+18:0] py_o
);

  localparam int unsigned MW = TRIG_FRAC_BITS + 1;
  localparam int unsigned SW = TRIG_FRAC_BITS + 2;
  localparam int unsigned PW = TRIG_FRAC_BITS + 19;
  localparam int unsigned SinShift = 30 - TRIG_FRAC_BITS;
  localparam logic [32:0] SinHalf  = 33'(1) << (29 - TRIG_FRAC_BITS);
  localparam logic [MW-1:0] SinOne = MW'(1) << TRIG_FRAC_BITS;

  logic [2:0] v_q;
  logic [2:0] en;

  logic [31:0] s_d [2];
  logic [31:0] s_q [2];
  logic [1:0]  quad_q;
  logic [15:0] dist1_q, dist2_q;

  logic signed [SW-1:0] sn_d, cs_d, sn_q, cs_q;
  logic signed [PW-1:0] px_d, py_d, px_q, py_q;
  logic signed [16:0]   dist_s;

  always_comb begin
    en[2] = !v_q[2] || out_ready_i;
    en[1] = !v_q[1] || en[2];
    en[0] = !v_q[0] || en[1];
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[2];
  assign px_o        = px_q;
  assign py_o        = py_q;

  // Stage 1: last Horner product gives the sine in Q30.
  always_comb begin
    logic [61:0] prod;
    for (int l = 0; l < 2; l++) begin
      prod   = 62'(in_item_i.lane[l].x) * 62'(in_item_i.lane[l].t);
      s_d[l] = prod[61:30];
    end
  end

  // Stage 2: round half up, clamp to one, and apply the quadrant symmetry.
  always_comb begin
    logic [32:0]          rnd;
    logic [MW-1:0]        mag  [2];
    logic signed [SW-1:0] sval [2];
    for (int l = 0; l < 2; l++) begin
      rnd     = (33'(s_q[l]) + SinHalf) >> SinShift;
      mag[l]  = (rnd > 33'(SinOne)) ? SinOne : MW'(rnd);
      sval[l] = $signed({1'b0, mag[l]});
    end
    case (quad_q)
      QUAD_0: begin
        sn_d = sval[LANE_A];
        cs_d = sval[LANE_B];
      end
      QUAD_1: begin
        sn_d = sval[LANE_B];
        cs_d = -sval[LANE_A];
      end
      QUAD_2: begin
        sn_d = -sval[LANE_A];
        cs_d = -sval[LANE_B];
      end
      default: begin
        sn_d = -sval[LANE_B];
        cs_d = sval[LANE_A];
      end
    endcase
  end

  // Stage 3: scale by the distance into the sensor frame, negating y when mirroring is on.
  always_comb begin
    logic signed [PW-1:0] dsn;
    dist_s = $signed({1'b0, dist2_q});
    px_d   = dist_s * cs_q;
    dsn    = dist_s * sn_q;
    py_d   = mirror_y_i ? -dsn : dsn;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      if (en[1]) v_q[1] <= v_q[0];
      if (en[2]) v_q[2] <= v_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s_q     <= s_d;
      quad_q  <= in_item_i.quad;
      dist1_q <= in_item_i.distance;
    end
    if (en[1]) begin
      sn_q    <= sn_d;
      cs_q    <= cs_d;
      dist2_q <= dist1_q;
    end
    if (en[2]) begin
      px_q <= px_d;
      py_q <= py_d;
    end
  end

endmodule

// ===== hdl/lp2w_rotate.sv =====
module lp2w_rotate import lp2w_pkg::*; #(
  parameter int unsigned TRIG_FRAC_BITS = 14
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  lp2w_cfg_t                         cfg_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [TRIG_FRAC_BITS+18:0] px_i,
  input  logic signed [TRIG_FRAC_BITS+18:0] py_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [31:0]                world_x_o,
  output logic signed [31:0]                world_y_o
);

  localparam int unsigned PW  = TRIG_FRAC_BITS + 19;
  localparam int unsigned MPW = PW + 16;
  localparam int unsigned SW  = MPW + 1;
  localparam int unsigned Sh  = POSE_FRAC_BITS + TRIG_FRAC_BITS;
  localparam int unsigned RW  = SW - Sh;
  localparam logic signed [SW-1:0] RndHalf = SW'(64'd1 << (Sh - 1));

  logic [2:0] v_q;
  logic [2:0] en;

  logic signed [MPW-1:0] cpx_q, spy_q, spx_q, cpy_q;
  logic signed [RW-1:0]  rx_d, ry_d, rx_q, ry_q;
  logic signed [31:0]    wx_d, wy_d, wx_q, wy_q;

  always_comb begin
    en[2] = !v_q[2] || out_ready_i;
    en[1] = !v_q[1] || en[2];
    en[0] = !v_q[0] || en[1];
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[2];
  assign world_x_o   = wx_q;
  assign world_y_o   = wy_q;

  // Stage 2: combine the products and round to nearest, ties upward.
  always_comb begin
    logic signed [SW-1:0] sx, sy, shx, shy;
    sx   = SW'(cpx_q) - SW'(spy_q) + RndHalf;
    sy   = SW'(spx_q) + SW'(cpy_q) + RndHalf;
    shx  = sx >>> Sh;
    shy  = sy >>> Sh;
    rx_d = shx[RW-1:0];
    ry_d = shy[RW-1:0];
  end

  // Stage 3: add the pose position.
  always_comb begin
    wx_d = 32'(rx_q) + 32'(cfg_i.pose_x);
    wy_d = 32'(ry_q) + 32'(cfg_i.pose_y);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      if (en[1]) v_q[1] <= v_q[0];
      if (en[2]) v_q[2] <= v_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      cpx_q <= MPW'(cfg_i.pose_cos) * MPW'(px_i);
      spy_q <= MPW'(cfg_i.pose_sin) * MPW'(py_i);
      spx_q <= MPW'(cfg_i.pose_sin) * MPW'(px_i);
      cpy_q <= MPW'(cfg_i.pose_cos) * MPW'(py_i);
    end
    if (en[1]) begin
      rx_q <= rx_d;
      ry_q <= ry_d;
    end
    if (en[2]) begin
      wx_q <= wx_d;
      wy_q <= wy_d;
    end
  end

endmodule

// ===== hdl/lidar_polar_to_world_point.sv =====
// Throughput: one point per cycle; every stage holds its item under back-pressure and
// collapses bubbles, so input is taken whenever any stage ahead has room.
// The 27 stages are three for angle reduction, three per Horner step of the sine
// (six steps), three for sine rounding and scaling, and three for the rotation.
// Reset clears all pipeline valid bits and loads the pose and mirror registers.
module lidar_polar_to_world_point import lp2w_pkg::*; #(
  parameter int unsigned TRIG_FRAC_BITS = 14
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [15:0]        angle_q6_i,
  input  logic [15:0]        distance_q2_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] world_x_o,
  output logic signed [31:0] world_y_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [30:0]        cfg_data_i
);

  localparam int unsigned PW = TRIG_FRAC_BITS + 19;

  lp2w_cfg_t cfg_q;

  lp2w_item_t item_s  [HORNER_STEPS+1];
  logic       valid_s [HORNER_STEPS+1];
  logic       ready_s [HORNER_STEPS+1];

  logic                 sin_valid, sin_ready;
  logic signed [PW-1:0] px, py;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pose_cos <= 16'sd16384;
      cfg_q.pose_sin <= '0;
      cfg_q.pose_x   <= '0;
      cfg_q.pose_y   <= '0;
      cfg_q.mirror_y <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_POSE_COS: cfg_q.pose_cos <= cfg_data_i[15:0];
        REG_POSE_SIN: cfg_q.pose_sin <= cfg_data_i[15:0];
        REG_POSE_X:   cfg_q.pose_x   <= cfg_data_i;
        REG_POSE_Y:   cfg_q.pose_y   <= cfg_data_i;
        REG_MIRROR_Y: cfg_q.mirror_y <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  lp2w_angle u_angle (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .angle_q6_i   (angle_q6_i),
    .distance_q2_i(distance_q2_i),
    .out_valid_o  (valid_s[0]),
    .out_ready_i  (ready_s[0]),
    .out_item_o   (item_s[0])
  );

  for (genvar k = 0; k < HORNER_STEPS; k++) begin : g_horner
    lp2w_horner #(
      .STEP(k)
    ) u_horner (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .in_valid_i (valid_s[k]),
      .in_ready_o (ready_s[k]),
      .in_item_i  (item_s[k]),
      .out_valid_o(valid_s[k+1]),
      .out_ready_i(ready_s[k+1]),
      .out_item_o (item_s[k+1])
    );
  end

  lp2w_sine_out #(
    .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
  ) u_sine_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .mirror_y_i (cfg_q.mirror_y),
    .in_valid_i (valid_s[HORNER_STEPS]),
    .in_ready_o (ready_s[HORNER_STEPS]),
    .in_item_i  (item_s[HORNER_STEPS]),
    .out_valid_o(sin_valid),
    .out_ready_i(sin_ready),
    .px_o       (px),
    .py_o       (py)
  );

  lp2w_rotate #(
    .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
  ) u_rotate (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (sin_valid),
    .in_ready_o (sin_ready),
    .px_i       (px),
    .py_i       (py),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .world_x_o  (world_x_o),
    .world_y_o  (world_y_o)
  );

endmodule

// ===== tb/tb.sv =====
module tb;
  import lp2w_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TRIG_FRAC      = 14;
  localparam int unsigned ROT_FRAC       = 14;
  localparam int unsigned PIPE_LATENCY   = 27;
  localparam int unsigned TIMEOUT_CYCLES = 200_000;
  localparam int unsigned ITEMS_PER_PHASE = 275;

  localparam int unsigned TURN_UNITS    = 23040;
  localparam int unsigned QUARTER_UNITS = 5760;
  localparam longint unsigned RAD_Q40   = 64'd299845282;
  localparam longint unsigned UNIT_Q30  = 64'd1 << 30;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
  } world_point_t;

  class point_scoreboard;
    world_point_t       expected_points[$];
    logic signed [15:0] pose_cos;
    logic signed [15:0] pose_sin;
    logic signed [30:0] pose_x;
    logic signed [30:0] pose_y;
    logic               mirror_y;
    int unsigned        mismatches;

    function new();
      pose_cos   = 16'sd16384;
      pose_sin   = '0;
      pose_x     = '0;
      pose_y     = '0;
      mirror_y   = 1'b1;
      mismatches = 0;
    endfunction

    function void set_register(logic [2:0] idx, logic [30:0] data);
      case (idx)
        REG_POSE_COS: pose_cos = data[15:0];
        REG_POSE_SIN: pose_sin = data[15:0];
        REG_POSE_X:   pose_x   = data;
        REG_POSE_Y:   pose_y   = data;
        REG_MIRROR_Y: mirror_y = data[0];
        default: ;
      endcase
    endfunction

    // Sine of an offset within one quarter turn, Taylor series in Horner form.
    function longint unsigned quarter_sine(int unsigned a);
      longint unsigned x, x2, t, s, r, div;
      x  = (64'(a) * RAD_Q40 + 64'd512) >> 10;
      x2 = (x * x) >> 30;
      t  = UNIT_Q30;
      for (int i = 0; i < 6; i++) begin
        case (i)
          0:       div = 156;
          1:       div = 110;
          2:       div = 72;
          3:       div = 42;
          4:       div = 20;
          default: div = 6;
        endcase
        t = UNIT_Q30 - ((x2 * t) >> 30) / div;
      end
      s = (x * t) >> 30;
      r = (s + (64'd1 << (29 - TRIG_FRAC))) >> (30 - TRIG_FRAC);
      if (r > (64'd1 << TRIG_FRAC)) r = 64'd1 << TRIG_FRAC;
      return r;
    endfunction

    // Round to nearest, ties towards plus infinity.
    function longint round_rotated(longint v);
      return (v + (64'sd1 <<< (ROT_FRAC + TRIG_FRAC - 1))) >>> (ROT_FRAC + TRIG_FRAC);
    endfunction

    function void note_measurement(logic [15:0] angle, logic [15:0] distance);
      int unsigned  reduced, offset;
      logic [1:0]   quad;
      longint       sa, sb, sn, cs, d, px, py, wx, wy;
      world_point_t p;
      reduced = angle % TURN_UNITS;
      quad    = 2'(reduced / QUARTER_UNITS);
      offset  = reduced % QUARTER_UNITS;
      sa = longint'(quarter_sine(offset));
      sb = longint'(quarter_sine(QUARTER_UNITS - offset));
      case (quad)
        QUAD_0: begin sn = sa;  cs = sb;  end
        QUAD_1: begin sn = sb;  cs = -sa; end
        QUAD_2: begin sn = -sa; cs = -sb; end
        default: begin sn = -sb; cs = sa; end
      endcase
      d  = longint'(distance);
      px = d * cs;
      py = mirror_y ? -(d * sn) : d * sn;
      wx = round_rotated(longint'(pose_cos) * px - longint'(pose_sin) * py) + longint'(pose_x);
      wy = round_rotated(longint'(pose_sin) * px + longint'(pose_cos) * py) + longint'(pose_y);
      p.x = wx[31:0];
      p.y = wy[31:0];
      expected_points.push_back(p);
    endfunction

    function void check_point(logic signed [31:0] x, logic signed [31:0] y);
      world_point_t p;
      if (expected_points.size() == 0) begin
        $error("unexpected point: world_x %0d world_y %0d", x, y);
        mismatches++;
        return;
      end
      p = expected_points.pop_front();
      if (x !== p.x) begin
        $error("world_x: expected %0d, actual %0d", p.x, x);
        mismatches++;
      end
      if (y !== p.y) begin
        $error("world_y: expected %0d, actual %0d", p.y, y);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return expected_points.size();
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni        = 1'b0;
  logic               in_valid_i    = 1'b0;
  logic               in_ready_o;
  logic [15:0]        angle_q6_i    = '0;
  logic [15:0]        distance_q2_i = '0;
  logic               out_valid_o;
  logic               out_ready_i   = 1'b0;
  logic signed [31:0] world_x_o;
  logic signed [31:0] world_y_o;
  logic               cfg_valid_i   = 1'b0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i   = '0;
  logic [30:0]        cfg_data_i    = '0;

  int unsigned     send_idle_pct = 0;
  int unsigned     stall_pct     = 0;
  point_scoreboard sb;

  lidar_polar_to_world_point #(
    .TRIG_FRAC_BITS(TRIG_FRAC)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .angle_q6_i   (angle_q6_i),
    .distance_q2_i(distance_q2_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .world_x_o    (world_x_o),
    .world_y_o    (world_y_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT_CYCLES * 10);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  // Every transfer is seen here with the values from before the edge.
  always @(posedge clk_i) begin
    if (rst_ni && sb != null) begin
      if (cfg_valid_i && cfg_ready_o) sb.set_register(cfg_index_i, cfg_data_i);
      if (in_valid_i && in_ready_o) sb.note_measurement(angle_q6_i, distance_q2_i);
      if (out_valid_o && out_ready_i) sb.check_point(world_x_o, world_y_o);
    end
  end

  task automatic send_measurement(input logic [15:0] angle, input logic [15:0] distance);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    angle_q6_i    <= angle;
    distance_q2_i <= distance;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [30:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
  endtask

  // Upper data bits above a register's width are filled at random; they must be ignored.
  task automatic write_pose(input int cos_v, input int sin_v, input int x_v, input int y_v,
                            input bit mirror);
    write_register(REG_POSE_COS, {15'($urandom), 16'(cos_v)});
    write_register(REG_POSE_SIN, {15'($urandom), 16'(sin_v)});
    write_register(REG_POSE_X, 31'(x_v));
    write_register(REG_POSE_Y, 31'(y_v));
    write_register(REG_MIRROR_Y, {30'($urandom), mirror});
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain_points();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic send_random_measurement();
    logic [15:0] angle, distance;
    // Quadrant boundaries are favoured, since the sine lanes swap there.
    if ($urandom_range(9) < 3)
      angle = 16'($urandom_range(11) * QUARTER_UNITS + $urandom_range(4)) - 16'd2;
    else
      angle = 16'($urandom);
    case ($urandom_range(9))
      0:       distance = '0;
      1:       distance = 16'hFFFF;
      2:       distance = 16'($urandom_range(255));
      default: distance = 16'($urandom);
    endcase
    send_measurement(angle, distance);
  endtask

  initial begin
    logic [15:0] reset_angles[16] = '{0, 0, 5760, 11520, 17280, 23039, 23040, 46080,
                                      65535, 1, 5759, 5761, 11519, 17281, 34560, 2880};
    logic [15:0] reset_dists[16]  = '{0, 65535, 65535, 65535, 65535, 65535, 40000, 1,
                                      65535, 65535, 65535, 65535, 1000, 1000, 12345, 65535};
    logic [15:0] edge_angles[6]   = '{0, 5760, 11520, 17280, 65535, 8000};
    logic [15:0] edge_dists[6]    = '{65535, 65535, 65535, 65535, 0, 65535};
    int unsigned idle_plan[4]     = '{0, 50, 0, 8};
    int unsigned stall_plan[4]    = '{0, 0, 50, 8};
    sb = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed points under the reset pose.
    foreach (reset_angles[i]) send_measurement(reset_angles[i], reset_dists[i]);
    drain_points();

    // Register patterns beyond the stated range, mirroring off, and unknown indexes.
    write_pose(-32768, 32767, -(1 << 30), (1 << 30) - 1, 1'b0);
    for (int idx = 5; idx < 8; idx++) write_register(3'(idx), 31'($urandom));
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    foreach (edge_angles[i]) send_measurement(edge_angles[i], edge_dists[i]);
    drain_points();

    for (int phase = 0; phase < 4; phase++) begin
      if (phase == 0)
        write_pose(16384, -16384, (1 << 30) - 1, -(1 << 30), 1'b1);
      else
        write_pose(int'($urandom_range(32768)) - 16384, int'($urandom_range(32768)) - 16384,
                   int'($urandom), int'($urandom), 1'($urandom));
      send_idle_pct = idle_plan[phase];
      stall_pct     = stall_plan[phase];
      repeat (ITEMS_PER_PHASE) send_random_measurement();
      drain_points();
    end

    stall_pct = 0;
    repeat (2 * PIPE_LATENCY) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== lidar_polar_to_world_point.f =====
hdl/lp2w_pkg.sv
hdl/lp2w_angle.sv
hdl/lp2w_horner.sv
hdl/lp2w_sine_out.sv
hdl/lp2w_rotate.sv
hdl/lidar_polar_to_world_point.sv
tb/tb.sv
